FILE: hdl/plpi_pkg.sv
// Types and constants for the piecewise-linear profile interpolator.
// No dependencies; imported by piecewise_linear_profile_interp.

package plpi_pkg;

  localparam int unsigned DEPTH_DEF  = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TEMP_W     = 21;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned PADDR_W    = 2;
  localparam int unsigned PDATA_W    = 32;
  localparam logic [CNT_W-1:0] POINT_COUNT_RST = CNT_W'(2);
  localparam logic [TEMP_W-1:0] TEMP_MAX = {TEMP_W{1'b1}};

  // register byte addresses
  localparam logic [PADDR_W-1:0] REG_POINT_COUNT = PADDR_W'(0);

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [3:0]        point_index;
    logic [TIME_W-1:0] time_value;
    logic [TEMP_W-1:0] point_temperature;
  } in_item_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic              below_first;
    logic              above_last;
    logic              saturated;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_value;
    logic [TEMP_W-1:0] temp_value;
  } point_t;

endpackage

FILE: hdl/piecewise_linear_profile_interp.sv
// A query runs from the accepting edge through reads of the last and first breakpoints, a
// scan over at most n breakpoints, n = point_count clamped to 2..DEPTH, and, for a segment
// of nonzero span, a serial divide, to the out_valid strobe. A new transaction is accepted
// in the strobe cycle at the earliest. Breakpoint writes are taken while idle and keep busy low. One query at a time.
// rst_n is synchronous: clears control state and sets point_count to 2; the table is not
// cleared. Results are strobed for one cycle on out_valid; the receiver cannot stall.

module piecewise_linear_profile_interp #(
  parameter int unsigned DEPTH = plpi_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  plpi_pkg::in_item_t             in_data,
  output logic                           out_valid,
  output plpi_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [plpi_pkg::PADDR_W-1:0]   paddr,
  input  logic [plpi_pkg::PDATA_W-1:0]   pwdata,
  output logic [plpi_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import plpi_pkg::*;

  localparam int unsigned AW        = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned DIV_STEPS = 54;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_LAST, S_FIRST, S_SCAN, S_MUL, S_ABS, S_DIV, S_ADD, S_OUT
  } state_t;

  state_t state_r;

  // breakpoint table
  point_t mem [DEPTH];
  point_t rdata_r;
  logic [AW-1:0] raddr;
  logic          wr_en;

  logic [CNT_W-1:0] point_count_r;

  logic [TIME_W-1:0] q_r;
  logic [AW-1:0]     last_idx_r;
  logic [AW-1:0]     idx_r;
  logic [TIME_W-1:0] t0_r, t1_r;
  logic [TEMP_W-1:0] y0_r, y1_r;
  logic              below_r, above_r;

  logic signed [54:0] prod_r;
  logic signed [32:0] span_r;
  logic [53:0]        dvd_r;
  logic [32:0]        dvs_r;
  logic [32:0]        rem_r;
  logic               neg_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [55:0]        res_r;

  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [8:0] n_clamp;
  logic [8:0] pc_ext;
  logic signed [21:0] dy;
  logic signed [32:0] dq;
  logic [33:0] rem_sh;
  logic        qbit;
  logic [53:0] prod_mag;
  logic [32:0] span_mag;

  logic accept;
  logic cfg_wr;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign wr_en  = accept && (in_data.kind == KIND_WRITE) &&
                  (9'(in_data.point_index) < 9'(DEPTH));

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_POINT_COUNT);
  assign prdata = (paddr == REG_POINT_COUNT) ? PDATA_W'(point_count_r) : '0;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // active point count clamped to [2, DEPTH]
  always_comb begin
    pc_ext = 9'(point_count_r);
    if (pc_ext < 9'd2) begin
      n_clamp = 9'd2;
    end else if (pc_ext > 9'(DEPTH)) begin
      n_clamp = 9'(DEPTH);
    end else begin
      n_clamp = pc_ext;
    end
  end

  always_comb begin
    case (state_r)
      S_IDLE:  raddr = AW'(n_clamp - 9'd1);
      S_LAST:  raddr = '0;
      S_FIRST: raddr = '0;
      S_SCAN:  raddr = AW'(idx_r + 1'b1);
      default: raddr = '0;
    endcase
  end

  always_comb begin
    dy       = $signed({1'b0, y1_r}) - $signed({1'b0, y0_r});
    dq       = $signed({1'b0, q_r}) - $signed({1'b0, t0_r});
    prod_mag = prod_r[54] ? 54'(-prod_r) : 54'(prod_r);
    span_mag = span_r[32] ? 33'(-span_r) : 33'(span_r);
    rem_sh   = {rem_r, dvd_r[53]};
    qbit     = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(in_data.point_index)] <= '{time_value: in_data.time_value,
                                         temp_value: in_data.point_temperature};
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= POINT_COUNT_RST;
    end else if (cfg_wr) begin
      point_count_r <= pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && (in_data.kind == KIND_QUERY)) begin
            q_r        <= in_data.time_value;
            last_idx_r <= AW'(n_clamp - 9'd1);
            state_r    <= S_LAST;
          end
        end
        S_LAST: begin
          // last breakpoint arrives here
          above_r <= (q_r >= rdata_r.time_value);
          state_r <= S_FIRST;
        end
        S_FIRST: begin
          idx_r   <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (idx_r == '0) begin
            below_r <= (q_r < rdata_r.time_value);
            t0_r    <= rdata_r.time_value;
            y0_r    <= rdata_r.temp_value;
            idx_r   <= idx_r + 1'b1;
          end else if (q_r <= rdata_r.time_value) begin
            t1_r    <= rdata_r.time_value;
            y1_r    <= rdata_r.temp_value;
            state_r <= S_MUL;
          end else if (idx_r == last_idx_r) begin
            // past the last breakpoint: hold last temperature
            res_r   <= 56'(rdata_r.temp_value);
            state_r <= S_OUT;
          end else begin
            t0_r  <= rdata_r.time_value;
            y0_r  <= rdata_r.temp_value;
            idx_r <= idx_r + 1'b1;
          end
        end
        S_MUL: begin
          prod_r  <= dy * dq;
          span_r  <= $signed({1'b0, t1_r}) - $signed({1'b0, t0_r});
          state_r <= S_ABS;
        end
        S_ABS: begin
          if (span_r == '0) begin
            res_r   <= 56'(y0_r);
            state_r <= S_OUT;
          end else begin
            dvd_r   <= prod_mag;
            dvs_r   <= span_mag;
            neg_r   <= prod_r[54] ^ span_r[32];
            rem_r   <= '0;
            dcnt_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          rem_r  <= qbit ? 33'(rem_sh - {1'b0, dvs_r}) : rem_sh[32:0];
          dvd_r  <= {dvd_r[52:0], qbit};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          res_r   <= neg_r ? (56'(y0_r) - 56'(dvd_r)) : (56'(y0_r) + 56'(dvd_r));
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r            <= 1'b1;
          out_data_r.below_first <= below_r;
          out_data_r.above_last  <= above_r;
          if (res_r[55]) begin
            out_data_r.temperature <= '0;
            out_data_r.saturated   <= 1'b1;
          end else if (res_r[54:0] > 55'(TEMP_MAX)) begin
            out_data_r.temperature <= TEMP_MAX;
            out_data_r.saturated   <= 1'b1;
          end else begin
            out_data_r.temperature <= res_r[TEMP_W-1:0];
            out_data_r.saturated   <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/piecewise_linear_profile_interp_tb.sv
`timescale 1ns / 100ps
// Testbench for piecewise_linear_profile_interp: breakpoint writes, APB point_count
// and temperature queries, checked against an interpolation predictor. Needs plpi_pkg.

class profile_scoreboard;
  logic [31:0] time_tab [16];
  logic [20:0] temp_tab [16];
  logic [4:0]  point_count_reg;
  plpi_pkg::out_item_t pending_q [$];
  int fails;

  function new();
    point_count_reg = plpi_pkg::POINT_COUNT_RST;
    fails = 0;
  endfunction

  task report(input string what);
    $display("ERROR @%0t: %s", $time, what);
    fails++;
  endtask

  function void set_count(input logic [4:0] v);
    point_count_reg = v;
  endfunction

  // first segment with q <= t[j+1]; signed quotient truncated toward zero
  function plpi_pkg::out_item_t interpolate(input logic [31:0] q);
    plpi_pkg::out_item_t res;
    int n;
    longint t0, t1, y0, y1, span, qq, r;
    bit hit;
    n = (point_count_reg < 2) ? 2 : (point_count_reg > 16) ? 16 : int'(point_count_reg);
    qq = longint'(q);
    r = longint'(temp_tab[n-1]);
    hit = 1'b0;
    for (int j = 0; j < n - 1 && !hit; j++) begin
      if (q <= time_tab[j+1]) begin
        t0 = longint'(time_tab[j]);
        t1 = longint'(time_tab[j+1]);
        y0 = longint'(temp_tab[j]);
        y1 = longint'(temp_tab[j+1]);
        span = t1 - t0;
        r = (span == 0) ? y0 : y0 + ((y1 - y0) * (qq - t0)) / span;
        hit = 1'b1;
      end
    end
    res.saturated = 1'b0;
    if (r < 0) begin
      r = 0;
      res.saturated = 1'b1;
    end else if (r > 64'sd2097151) begin
      r = 64'sd2097151;
      res.saturated = 1'b1;
    end
    res.temperature = r[20:0];
    res.below_first = (q < time_tab[0]);
    res.above_last  = (q >= time_tab[n-1]);
    return res;
  endfunction

  function void note_input(input plpi_pkg::in_item_t it);
    if (it.kind == plpi_pkg::KIND_WRITE) begin
      time_tab[it.point_index] = it.time_value;
      temp_tab[it.point_index] = it.point_temperature;
    end else begin
      pending_q = {pending_q, interpolate(it.time_value)};
    end
  endfunction

  task check_result(input plpi_pkg::out_item_t got);
    plpi_pkg::out_item_t want;
    if (pending_q.size() == 0) begin
      report("result strobed with no query outstanding");
      return;
    end
    want = pending_q.pop_front();
    if (got.temperature !== want.temperature)
      report($sformatf("temperature got %h want %h", got.temperature, want.temperature));
    if (got.below_first !== want.below_first)
      report($sformatf("below_first got %b want %b", got.below_first, want.below_first));
    if (got.above_last !== want.above_last)
      report($sformatf("above_last got %b want %b", got.above_last, want.above_last));
    if (got.saturated !== want.saturated)
      report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
  endtask
endclass

module piecewise_linear_profile_interp_tb;
  import plpi_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  profile_scoreboard sb = new();
  int items_sent = 0;
  bit quiet = 1'b0;
  logic [31:0] gen_time [16];
  logic [4:0] count_sel;

  piecewise_linear_profile_interp u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_input(in_data);
      if (out_valid) sb.check_result(out_data);
    end
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(70, 8);
  endfunction

  // holds start high until the transaction is taken
  task automatic send_item(input in_item_t it);
    int gap;
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    items_sent++;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_write(input logic [3:0] idx, input logic [31:0] t, input logic [20:0] tk);
    in_item_t it;
    it.kind = KIND_WRITE;
    it.point_index = idx;
    it.time_value = t;
    it.point_temperature = tk;
    gen_time[idx] = t;
    send_item(it);
  endtask

  task automatic put_query(input logic [31:0] q);
    in_item_t it;
    it.kind = KIND_QUERY;
    it.point_index = 4'($urandom);
    it.time_value = q;
    it.point_temperature = 21'($urandom);
    send_item(it);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write transaction followed back to back by a readback
  task automatic cfg_write_check(input logic [4:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_POINT_COUNT;
    pwdata <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_count(v);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(v))
      sb.report($sformatf("point_count readback %h want %h", prdata, v));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic fill_table(input bit sorted);
    logic [31:0] t;
    int unsigned step_max;
    step_max = ($urandom_range(1) == 0) ? $urandom_range(64, 1) : $urandom_range(1 << 27, 1);
    t = ($urandom_range(1) == 0) ? $urandom_range(1000) : $urandom_range(32'h7FFF_FFFF);
    for (int i = 0; i < 16; i++) begin
      put_write(4'(i), sorted ? t : $urandom, 21'($urandom));
      if ($urandom_range(9) != 0) t = t + $urandom_range(step_max, 1);
    end
  endtask

  function automatic logic [31:0] pick_query(input int n);
    longint unsigned lo, hi;
    int sel, k;
    sel = $urandom_range(99);
    if (sel < 50) begin
      k = $urandom_range(n - 2);
      lo = gen_time[k];
      hi = gen_time[k+1];
      if (hi < lo) begin
        lo = gen_time[k+1];
        hi = gen_time[k];
      end
      return 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
    end
    if (sel < 65) return gen_time[$urandom_range(n - 1)];
    if (sel < 75) return (gen_time[0] == 0) ? 32'd0 : $urandom_range(gen_time[0] - 1);
    if (sel < 85) begin
      lo = gen_time[n-1];
      return 32'(lo + ({$urandom, $urandom} % (64'h1_0000_0000 - lo)));
    end
    return $urandom;
  endfunction

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: count at reset value, two-point profiles
    put_write(4'd0, 32'd100, 21'h100000);
    put_write(4'd1, 32'd200, 21'h000000);
    put_query(32'd0);            // extrapolates past the top, clamps
    put_query(32'd100);
    put_query(32'd150);
    put_query(32'd200);
    put_query(32'hFFFF_FFFF);
    put_write(4'd1, 32'd100, 21'h1FFFFF);   // zero-length segment
    put_query(32'd100);
    put_query(32'd50);
    put_query(32'd101);
    put_write(4'd0, 32'd1000, 21'h000000);
    put_write(4'd1, 32'd2000, 21'h1FFFFF);
    put_query(32'd0);            // extrapolates below zero, clamps
    put_query(32'd1500);
    put_write(4'd0, 32'hFFFF_FFFF, 21'd5);  // descending times
    put_write(4'd1, 32'd0, 21'h1FFFFF);
    put_query(32'd0);
    put_query(32'h8000_0000);
    put_query(32'hFFFF_FFFF);
    put_write(4'd15, 32'hFFFF_FFFF, 21'h1FFFFF);

    // random phases, each on a fresh table and count
    for (int p = 0; items_sent < 1270; p++) begin
      wait_idle();
      case (p)
        0: count_sel = 5'd16;
        1: count_sel = 5'd0;
        2: count_sel = 5'd31;
        3: count_sel = 5'd1;
        4: count_sel = 5'd17;
        5: count_sel = 5'd2;
        default: count_sel = ($urandom_range(4) == 0) ? 5'($urandom) : 5'($urandom_range(16, 2));
      endcase
      cfg_write_check(count_sel);
      n = (count_sel < 2) ? 2 : (count_sel > 16) ? 16 : int'(count_sel);
      quiet = ($urandom_range(3) == 0);
      fill_table($urandom_range(4) != 0);
      repeat (84) begin
        if ($urandom_range(9) == 0)
          put_write(4'($urandom), $urandom, 21'($urandom));
        else
          put_query(pick_query(n));
      end
    end

    wait_idle();
    repeat (80) @(posedge clk);
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
